// ----- rtl/dids_pkg.sv -----
// shared types and constants for the distinct id set counter
package dids_pkg;

  localparam int CAPACITY = 50;
  localparam int ID_W     = 32;
  localparam int OUT_W    = 6;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef struct packed {
    logic [ID_W-1:0] offered_id;
    logic            present;
  } in_req_t;

  typedef struct packed {
    logic             newly_stored;
    logic [OUT_W-1:0] distinct_count;
    logic             set_full;
  } out_rsp_t;

  // control from the sequencer to the shared compare unit
  typedef struct packed {
    logic clear;
    logic en;
  } cmp_ctrl_t;

endpackage

// ----- rtl/dids_ram.sv -----
// generic single write port ram with registered read
module dids_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/dids_cmp.sv -----
// shared equality compare unit with sticky hit flag
module dids_cmp (
  input  logic                      clk,
  input  logic                      rst,
  input  dids_pkg::cmp_ctrl_t       ctrl,
  input  logic [dids_pkg::ID_W-1:0] rd_data,
  input  logic [dids_pkg::ID_W-1:0] key,
  output logic                      hit
);
  import dids_pkg::*;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      hit <= 1'b0;
    end else if (ctrl.en && (rd_data == key)) begin
      hit <= 1'b1;
    end
  end

endmodule

// ----- rtl/distinct_id_set_counter_core.sv -----
// top level: distinct id set with a sequencer walking stored entries
// flow: a skipped request (not present, own id, or set full) or one seen with
//   an empty set goes straight to the finish step; others scan and drain first
// throughput: one request at a time; the stored ids are walked linearly through
//   the single read port of the id ram and one comparator
// reset (rst, synchronous): count, own id and output valid clear; the id ram is
//   not cleared since only entries below the count are ever read
module distinct_id_set_counter_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [dids_pkg::ID_W-1:0]   cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  dids_pkg::in_req_t           in_req,
  output logic                        out_valid,
  input  logic                        out_stall,
  output dids_pkg::out_rsp_t          out_rsp
);
  import dids_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  state_t            state;
  logic [ID_W-1:0]   own_id;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W-1:0]  scan_idx;
  logic [ID_W-1:0]   key;
  logic              skip;
  logic              cmp_en;
  logic              hit;
  logic [ID_W-1:0]   rd_data;
  cmp_ctrl_t         cmp_ctrl;

  logic in_accept;
  logic skip_now;
  logic out_free;
  logic added;
  logic scan_last;
  logic wr_en;

  // only take a request when the sequencer is parked
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  // requests that never touch the set
  assign skip_now = !in_req.present || (in_req.offered_id == own_id) || (count >= CAP_CNT);

  // output register can take a new result
  assign out_free = !out_valid || !out_stall;

  assign added      = !skip && !hit;
  assign count_next = count + CNT_W'(added);
  assign scan_last  = (scan_idx == (count - CNT_W'(1)));
  assign wr_en      = (state == S_FIN) && out_free && added;

  assign cmp_ctrl.clear = in_accept;
  assign cmp_ctrl.en    = cmp_en;

  // id storage, one read per scan cycle, one write at the end of a request that adds its id
  dids_ram #(
    .WIDTH (ID_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count[ADDR_W-1:0]),
    .wdata (key),
    .re    (state == S_SCAN),
    .raddr (scan_idx[ADDR_W-1:0]),
    .rdata (rd_data)
  );

  // single comparator, fed one stored id per cycle while scanning
  dids_cmp u_cmp (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (cmp_ctrl),
    .rd_data (rd_data),
    .key     (key),
    .hit     (hit)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      own_id    <= '0;
      count     <= '0;
      out_valid <= 1'b0;
      cmp_en    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        own_id <= cfg_wr_data;
      end
      // read data is valid in the cycle after a scan read
      cmp_en <= (state == S_SCAN);
      // a new result replaces the one taken in the same cycle
      if ((state == S_FIN) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            state <= (skip_now || (count == '0)) ? S_FIN : S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_last) begin
            state <= S_DRAIN;
          end
        end
        // last compare lands here
        S_DRAIN: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            count     <= count_next;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      key      <= in_req.offered_id;
      skip     <= skip_now;
      scan_idx <= '0;
    end else if (state == S_SCAN) begin
      scan_idx <= scan_idx + CNT_W'(1);
    end
    if ((state == S_FIN) && out_free) begin
      out_rsp.newly_stored   <= added;
      out_rsp.distinct_count <= OUT_W'(count_next);
      out_rsp.set_full       <= (count_next >= CAP_CNT);
    end
  end

  // count stays within capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_CNT)
    else $error("count above capacity");

  // count grows by one only, outside reset
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (count != $past(count))) |-> (count == $past(count) + CNT_W'(1)))
    else $error("count jumped");

  // a new result only comes out of the finish step
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FIN))
    else $error("result without finish step");

  // scan never reads beyond occupied entries
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (scan_idx < count))
    else $error("scan past occupied entries");

  // ram write only on a real insertion into a set that has room
  a_wr_room: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (!skip && (count < CAP_CNT)))
    else $error("write into full set");

endmodule
